@@ rtl/core/ecd_pkg.sv @@
// ----------------------------------------------------------------------------
// Epoch-to-civil-date package
// Shared types, constants and the month start table for the epoch seconds to
// civil date unit.
// ----------------------------------------------------------------------------
package ecd_pkg;

  // Field widths
  localparam int SECS_W  = 32;
  localparam int MS_W    = 10;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // Internal widths
  localparam int DAYS_W = 16;  // up to 49710 days
  localparam int SOD_W  = 17;  // seconds of the day, below 86400
  localparam int Z_W    = 20;  // day number from the March-based zero
  localparam int DOE_W  = 18;  // day of the 400-year era
  localparam int YOE_W  = 9;   // year of the era, below 400
  localparam int DOY_W  = 9;   // day of the March-based year, below 366
  localparam int SOH_W  = 12;  // seconds of the hour, below 3600
  localparam int MP_W   = 4;   // March-based month index, 0..11

  // Calendar constants
  localparam logic [31:0]      SECS_PER_DAY    = 32'd86400;
  localparam logic [SOD_W-1:0] SECS_PER_HOUR   = 17'd3600;
  localparam logic [SOH_W-1:0] SECS_PER_MIN    = 12'd60;
  localparam logic [Z_W-1:0]   EPOCH_TO_MARCH0 = 20'd719468;
  localparam logic [Z_W-1:0]   ERA4_START      = 20'd584388;  // 4 * 146097
  localparam logic [Z_W-1:0]   ERA5_START      = 20'd730485;  // 5 * 146097
  localparam logic [YEAR_W-1:0] ERA4_YEAR      = 12'd1600;
  localparam logic [YEAR_W-1:0] ERA5_YEAR      = 12'd2000;

  // Reciprocal multipliers: floor(x / d) = (x * M) >> K for the stated x range
  localparam logic [25:0] DAY_RCP  = 26'd50903317;  // /675, x < 2^25, K = 35
  localparam int          DAY_SH   = 35;
  localparam logic [16:0] Y4_RCP   = 17'd91930;     // /365, x < 2^16, K = 25
  localparam int          Y4_SH    = 25;
  localparam logic [18:0] YR_RCP   = 19'd367720;    // /365, x < 2^18, K = 27
  localparam int          YR_SH    = 27;
  localparam logic [13:0] HOUR_RCP = 14'd9321;      // /225, x < 2^13, K = 21
  localparam int          HOUR_SH  = 21;
  localparam logic [10:0] MIN_RCP  = 11'd1093;      // /15,  x < 2^10, K = 14
  localparam int          MIN_SH   = 14;

  // Century boundaries inside one era (multiples of 36524)
  localparam logic [DOE_W-1:0] CENT1   = 18'd36524;
  localparam logic [DOE_W-1:0] CENT2   = 18'd73048;
  localparam logic [DOE_W-1:0] CENT3   = 18'd109572;
  localparam logic [DOE_W-1:0] ERA_END = 18'd146096;

  // Pipeline depth between the input register and the result register
  localparam int PIPE_LAT = 6;

  typedef struct packed {
    logic [SECS_W-1:0] whole_seconds;
    logic [MS_W-1:0]   milliseconds_in;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [MS_W-1:0]    milliseconds_out;
  } out_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

  // First day of each March-based month: (153 * mp + 2) / 5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/epoch_seconds_to_civil_date_unit.sv @@
// ----------------------------------------------------------------------------
// Epoch seconds to civil date unit
// Converts seconds since 1970-01-01 00:00:00 plus a millisecond fraction into
// Gregorian date and time of day.
//
//   channel   handshake          payload
//   --------  -----------------  ----------------------------------------
//   command   start / busy       item   (whole_seconds, milliseconds_in)
//   result    done (1 cycle)     result (date, time of day, milliseconds)
//
// One item is taken in every cycle while busy is low; each result follows its
// start through the input register, six pipeline stages and the result
// register. busy is high during reset and for the cycle after it, and low
// otherwise. Results are shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_date_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ecd_pkg::in_item_t  item,
  output logic               done,
  output ecd_pkg::out_item_t result
);

  logic                               in_valid;
  ecd_pkg::in_item_t                  in_q;
  logic [ecd_pkg::PIPE_LAT-1:0]       vld_pipe;
  logic [ecd_pkg::MS_W-1:0]           ms_pipe [ecd_pkg::PIPE_LAT];
  logic [ecd_pkg::DAYS_W-1:0]         days;
  logic [ecd_pkg::SOD_W-1:0]          sod;
  ecd_pkg::date_t                     date;
  ecd_pkg::tod_t                      tod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
      vld_pipe <= '0;
      done     <= 1'b0;
    end else begin
      busy     <= 1'b0;
      in_valid <= start & ~busy;
      vld_pipe <= {vld_pipe[ecd_pkg::PIPE_LAT-2:0], in_valid};
      done     <= vld_pipe[ecd_pkg::PIPE_LAT-1];
    end
  end

  // Payload path: load every cycle, qualified by the valid chain
  always_ff @(posedge clk) begin
    in_q       <= item;
    ms_pipe[0] <= in_q.milliseconds_in;
    for (int i = 1; i < ecd_pkg::PIPE_LAT; i++) begin
      ms_pipe[i] <= ms_pipe[i-1];
    end
  end

  ecd_day_split u_day_split (
    .clk  (clk),
    .secs (in_q.whole_seconds),
    .days (days),
    .sod  (sod)
  );

  ecd_date u_date (
    .clk  (clk),
    .days (days),
    .date (date)
  );

  ecd_tod u_tod (
    .clk (clk),
    .sod (sod),
    .tod (tod)
  );

  always_ff @(posedge clk) begin
    result.year             <= date.year;
    result.month            <= date.month;
    result.day_of_month     <= date.day_of_month;
    result.hour             <= tod.hour;
    result.minute           <= tod.minute;
    result.second           <= tod.second;
    result.milliseconds_out <= ms_pipe[ecd_pkg::PIPE_LAT-1];
  end

endmodule

@@ rtl/core/ecd_day_split.sv @@
// ----------------------------------------------------------------------------
// Day split
// Two registered stages: whole seconds to day count by reciprocal multiply,
// then the seconds of the day as the remainder.
// ----------------------------------------------------------------------------
module ecd_day_split (
  input  logic                              clk,
  input  logic [ecd_pkg::SECS_W-1:0]        secs,
  output logic [ecd_pkg::DAYS_W-1:0]        days,
  output logic [ecd_pkg::SOD_W-1:0]         sod
);

  logic [50:0]                       day_prod;
  logic [ecd_pkg::DAYS_W-1:0]        days_s1;
  logic [ecd_pkg::SECS_W-1:0]        secs_s1;
  logic [31:0]                       day_secs;
  logic [31:0]                       sod_full;

  // 86400 = 128 * 675: shift first, then divide by 675
  assign day_prod = 51'(secs[31:7]) * 51'(ecd_pkg::DAY_RCP);

  always_ff @(posedge clk) begin
    days_s1 <= day_prod[50:ecd_pkg::DAY_SH];
    secs_s1 <= secs;
  end

  assign day_secs = 32'(days_s1) * ecd_pkg::SECS_PER_DAY;
  assign sod_full = secs_s1 - day_secs;

  always_ff @(posedge clk) begin
    days <= days_s1;
    sod  <= sod_full[ecd_pkg::SOD_W-1:0];
  end

endmodule

@@ rtl/core/ecd_tod.sv @@
// ----------------------------------------------------------------------------
// Time of day
// Four registered stages turning the seconds of the day into hour, minute
// and second.
// ----------------------------------------------------------------------------
module ecd_tod (
  input  logic                       clk,
  input  logic [ecd_pkg::SOD_W-1:0]  sod,
  output ecd_pkg::tod_t              tod
);

  logic [26:0]                       hr_prod;
  logic [ecd_pkg::HOUR_W-1:0]        hr_t1, hr_t2, hr_t3;
  logic [ecd_pkg::SOD_W-1:0]         sod_t1;
  logic [ecd_pkg::SOD_W-1:0]         soh_full;
  logic [ecd_pkg::SOH_W-1:0]         soh_t2, soh_t3;
  logic [20:0]                       mn_prod;
  logic [ecd_pkg::MIN_W-1:0]         mn_t3;
  logic [ecd_pkg::SOH_W-1:0]         sc_full;

  // 3600 = 16 * 225
  assign hr_prod = 27'(sod[ecd_pkg::SOD_W-1:4]) * 27'(ecd_pkg::HOUR_RCP);

  always_ff @(posedge clk) begin
    hr_t1  <= hr_prod[25:ecd_pkg::HOUR_SH];
    sod_t1 <= sod;
  end

  assign soh_full = sod_t1 - (ecd_pkg::SOD_W'(hr_t1) * ecd_pkg::SECS_PER_HOUR);

  always_ff @(posedge clk) begin
    hr_t2  <= hr_t1;
    soh_t2 <= soh_full[ecd_pkg::SOH_W-1:0];
  end

  // 60 = 4 * 15
  assign mn_prod = 21'(soh_t2[ecd_pkg::SOH_W-1:2]) * 21'(ecd_pkg::MIN_RCP);

  always_ff @(posedge clk) begin
    hr_t3  <= hr_t2;
    soh_t3 <= soh_t2;
    mn_t3  <= mn_prod[19:ecd_pkg::MIN_SH];
  end

  assign sc_full = soh_t3 - (ecd_pkg::SOH_W'(mn_t3) * ecd_pkg::SECS_PER_MIN);

  always_ff @(posedge clk) begin
    tod.hour   <= hr_t3;
    tod.minute <= mn_t3;
    tod.second <= sc_full[ecd_pkg::SEC_W-1:0];
  end

endmodule

@@ rtl/core/ecd_date.sv @@
// ----------------------------------------------------------------------------
// Civil date
// Day count to Gregorian year, month and day over four registered stages,
// with the month lookup after the last register.
// ----------------------------------------------------------------------------
module ecd_date (
  input  logic                        clk,
  input  logic [ecd_pkg::DAYS_W-1:0]  days,
  output ecd_pkg::date_t              date
);

  logic [ecd_pkg::Z_W-1:0]    z;
  logic                       era5_full;
  logic [ecd_pkg::Z_W-1:0]    doe_full;

  logic                       era5_p1, era5_p2, era5_p3, era5_p4;
  logic [ecd_pkg::DOE_W-1:0]  doe_p1, doe_p2, doe_p3;

  logic [32:0]                q4_prod;
  logic [6:0]                 q4;
  logic [2:0]                 cent;
  logic [18:0]                num_full;
  logic [ecd_pkg::DOE_W-1:0]  num_p2;

  logic [36:0]                yr_prod;
  logic [ecd_pkg::YOE_W-1:0]  yoe_p3, yoe_p4;

  logic [1:0]                 yoe_cent;
  logic [ecd_pkg::DOE_W-1:0]  year_base;
  logic [ecd_pkg::DOE_W-1:0]  doy_full;
  logic [ecd_pkg::DOY_W-1:0]  doy_p4;

  logic [ecd_pkg::MP_W-1:0]   mp;
  logic [ecd_pkg::DOY_W-1:0]  dom_full;
  logic [ecd_pkg::MONTH_W-1:0] mon;
  logic [ecd_pkg::YEAR_W-1:0] yr;

  // Stage 1: era and day of era; the day range spans only eras 4 and 5
  assign z         = ecd_pkg::Z_W'(days) + ecd_pkg::EPOCH_TO_MARCH0;
  assign era5_full = (z >= ecd_pkg::ERA5_START);
  assign doe_full  = z - (era5_full ? ecd_pkg::ERA5_START : ecd_pkg::ERA4_START);

  always_ff @(posedge clk) begin
    era5_p1 <= era5_full;
    doe_p1  <= doe_full[ecd_pkg::DOE_W-1:0];
  end

  // Stage 2: remove leap days from the day of era
  assign q4_prod = 33'(doe_p1[ecd_pkg::DOE_W-1:2]) * 33'(ecd_pkg::Y4_RCP);
  assign q4      = q4_prod[31:ecd_pkg::Y4_SH];
  assign cent    = 3'(doe_p1 >= ecd_pkg::CENT1) + 3'(doe_p1 >= ecd_pkg::CENT2) +
                   3'(doe_p1 >= ecd_pkg::CENT3) + 3'(doe_p1 >= ecd_pkg::ERA_END);
  assign num_full = 19'(doe_p1) - 19'(q4) + 19'(cent) - 19'(doe_p1 == ecd_pkg::ERA_END);

  always_ff @(posedge clk) begin
    era5_p2 <= era5_p1;
    doe_p2  <= doe_p1;
    num_p2  <= num_full[ecd_pkg::DOE_W-1:0];
  end

  // Stage 3: year of era
  assign yr_prod = 37'(num_p2) * 37'(ecd_pkg::YR_RCP);

  always_ff @(posedge clk) begin
    era5_p3 <= era5_p2;
    doe_p3  <= doe_p2;
    yoe_p3  <= yr_prod[35:ecd_pkg::YR_SH];
  end

  // Stage 4: day of the March-based year
  assign yoe_cent  = 2'(yoe_p3 >= 9'd100) + 2'(yoe_p3 >= 9'd200) + 2'(yoe_p3 >= 9'd300);
  assign year_base = ecd_pkg::DOE_W'(yoe_p3) * 18'd365 + ecd_pkg::DOE_W'(yoe_p3[8:2]) -
                     ecd_pkg::DOE_W'(yoe_cent);
  assign doy_full  = doe_p3 - year_base;

  always_ff @(posedge clk) begin
    era5_p4 <= era5_p3;
    yoe_p4  <= yoe_p3;
    doy_p4  <= doy_full[ecd_pkg::DOY_W-1:0];
  end

  // Month lookup: last month whose first day is not past doy
  always_comb begin
    mp = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy_p4 >= ecd_pkg::month_start(ecd_pkg::MP_W'(i))) begin
        mp = ecd_pkg::MP_W'(i);
      end
    end
  end

  assign dom_full = doy_p4 - ecd_pkg::month_start(mp) + 9'd1;
  assign mon      = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
  assign yr       = ecd_pkg::YEAR_W'(yoe_p4) +
                    (era5_p4 ? ecd_pkg::ERA5_YEAR : ecd_pkg::ERA4_YEAR) +
                    ecd_pkg::YEAR_W'(mon <= 4'd2);

  assign date.year         = yr;
  assign date.month        = mon;
  assign date.day_of_month = dom_full[ecd_pkg::DOM_W-1:0];

endmodule

@@ sim/epoch_seconds_to_civil_date_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Epoch seconds to civil date unit testbench
// Sends timestamps through the start/busy command port and checks every done
// result against a date and time computed in the bench, field by field. A
// directed set covers the calendar edges, then random timestamps run with the
// sender back to back, mostly idle and lightly idle.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_date_unit_tb;

  localparam int unsigned DAY_SECONDS     = 86400;
  localparam int unsigned HOUR_SECONDS    = 3600;
  localparam int unsigned MINUTE_SECONDS  = 60;
  localparam int unsigned ERA_DAYS        = 146097;
  localparam int unsigned EPOCH_DAY_SHIFT = 719468;
  localparam int unsigned LAST_FULL_DAY   = 49709;
  localparam int          SETTLE_CYCLES   = 16;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  ecd_pkg::in_item_t      item;
  logic                   done;
  ecd_pkg::out_item_t     result;

  ecd_pkg::out_item_t     expected_dates[$];
  int unsigned            mismatch_count;
  int unsigned            sender_idle_pct;

  epoch_seconds_to_civil_date_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Days are shifted to a March-based count so the leap day ends the year.
  function automatic ecd_pkg::out_item_t civil_from_epoch(input ecd_pkg::in_item_t it);
    ecd_pkg::out_item_t r;
    int unsigned days, sod, z, era, doe, yoe, yr, doy, mp, dom, mon, hr, mn, sc;
    days = it.whole_seconds / DAY_SECONDS;
    sod  = it.whole_seconds - days * DAY_SECONDS;
    z    = days + EPOCH_DAY_SHIFT;
    era  = z / ERA_DAYS;
    doe  = z - era * ERA_DAYS;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr   = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dom  = doy - (153 * mp + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    if (mon <= 2) yr = yr + 1;
    hr   = sod / HOUR_SECONDS;
    sod  = sod - hr * HOUR_SECONDS;
    mn   = sod / MINUTE_SECONDS;
    sc   = sod - mn * MINUTE_SECONDS;
    r.year             = yr[ecd_pkg::YEAR_W-1:0];
    r.month            = mon[ecd_pkg::MONTH_W-1:0];
    r.day_of_month     = dom[ecd_pkg::DOM_W-1:0];
    r.hour             = hr[ecd_pkg::HOUR_W-1:0];
    r.minute           = mn[ecd_pkg::MIN_W-1:0];
    r.second           = sc[ecd_pkg::SEC_W-1:0];
    r.milliseconds_out = it.milliseconds_in;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // Record each transfer and check each result against the oldest expected date.
  always @(posedge clk) begin : check_results
    ecd_pkg::out_item_t want;
    if (!rst) begin
      if (start && !busy) expected_dates.push_back(civil_from_epoch(item));
      if (done) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result with no timestamp outstanding");
        end else begin
          want = expected_dates.pop_front();
          compare_field("year", 32'(want.year), 32'(result.year));
          compare_field("month", 32'(want.month), 32'(result.month));
          compare_field("day_of_month", 32'(want.day_of_month),
                        32'(result.day_of_month));
          compare_field("hour", 32'(want.hour), 32'(result.hour));
          compare_field("minute", 32'(want.minute), 32'(result.minute));
          compare_field("second", 32'(want.second), 32'(result.second));
          compare_field("milliseconds_out", 32'(want.milliseconds_out),
                        32'(result.milliseconds_out));
        end
      end
    end
  end

  task automatic send_timestamp(input logic [31:0] secs, input logic [9:0] ms);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    item  <= '{whole_seconds: secs, milliseconds_in: ms};
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every outstanding date has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_seconds();
    logic [31:0] s;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: s = $urandom;
      5, 6:          s = $urandom_range(LAST_FULL_DAY) * DAY_SECONDS;
      7:             s = $urandom_range(LAST_FULL_DAY) * DAY_SECONDS + DAY_SECONDS - 1;
      8:             s = 32'hFFFF_FFFF - $urandom_range(200000);
      default:       s = $urandom_range(100000000);
    endcase
    return s;
  endfunction

  function automatic logic [9:0] pick_milliseconds();
    if ($urandom_range(9) == 0) return 10'($urandom_range(1023, 1000));
    return 10'($urandom_range(999));
  endfunction

  task automatic test_calendar_edges();
    sender_idle_pct = 0;
    send_timestamp(32'd0, 10'd0);                // the epoch itself
    send_timestamp(32'hFFFF_FFFF, 10'd999);      // last representable second
    send_timestamp(32'd86399, 10'd1023);         // end of first day, ms above 999
    send_timestamp(32'd86400, 10'd1000);
    send_timestamp(32'd31535999, 10'd1);         // 1970-12-31 23:59:59
    send_timestamp(32'd31536000, 10'd500);
    send_timestamp(32'd68169599, 10'h2AA);       // 1972-02-28 23:59:59
    send_timestamp(32'd68169600, 10'h155);       // first leap day after the epoch
    send_timestamp(32'd68256000, 10'd0);         // 1972-03-01
    send_timestamp(32'd946684799, 10'd999);      // 1999-12-31 23:59:59
    send_timestamp(32'd951782400, 10'd12);       // 2000-02-29, leap century
    send_timestamp(32'd951868800, 10'd34);
    send_timestamp(32'd2147483647, 10'd0);
    send_timestamp(32'd2147483648, 10'd1023);
    send_timestamp(32'd4107542399, 10'd7);       // 2100-02-28, no leap day that year
    send_timestamp(32'd4107542400, 10'd8);       // 2100-03-01
    send_timestamp(32'hAAAA_AAAA, 10'h2AA);
    send_timestamp(32'h5555_5555, 10'h155);
    send_timestamp(32'd4294944000, 10'd0);       // start of the last, partial day
    send_timestamp(32'd4294943999, 10'd999);
  endtask

  task automatic test_random_timestamps(input int unsigned count,
                                        input int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_timestamp(pick_seconds(), pick_milliseconds());
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    item            = '0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_calendar_edges();
    test_random_timestamps(400, 0);
    wait_for_results();
    test_random_timestamps(400, 73);
    wait_for_results();
    test_random_timestamps(350, 6);
    wait_for_results();

    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
